>>> design/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg: shared types and constants of the front-end frame deframer
// Holds the parser phase encoding, result and configuration structs, and
// the frame constants.
// ----------------------------------------------------------------------------
package ffd_pkg;

	localparam logic [7:0] SYNC_A = 8'hEB;
	localparam logic [7:0] SYNC_B = 8'h90;

	// frames shorter than the fixed header overhead carry no channels
	localparam logic [15:0] HDR_LEN = 16'd6;

	// ceil(2^17 / 3): exact quotient by 3 for any 16-bit dividend
	localparam logic [16:0] DIV3_MUL   = 17'd43691;
	localparam int          DIV3_SHIFT = 17;

	localparam logic [2:0] SKIP_BYTES = 3'd4;

	localparam int CHAN_W = 9;
	localparam int LEFT_W = 15;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_FULL_AB = 2'd0;
	localparam cfg_index_t CFG_FULL_C  = 2'd1;
	localparam cfg_index_t CFG_FEES    = 2'd2;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_SAMPLE = 2'd0;
	localparam kind_t KIND_EVENT  = 2'd1;
	localparam kind_t KIND_ERROR  = 2'd2;

	typedef logic [2:0] err_t;
	localparam err_t ERR_NONE    = 3'd0;
	localparam err_t ERR_SYNC1   = 3'd1;
	localparam err_t ERR_SYNC2   = 3'd2;
	localparam err_t ERR_TRIGGER = 3'd3;
	localparam err_t ERR_MODE    = 3'd4;

	typedef enum logic [10:0] {
		PH_IDLE  = 11'b000_0000_0001,
		PH_SYNC1 = 11'b000_0000_0010,
		PH_SYNC2 = 11'b000_0000_0100,
		PH_TRIG  = 11'b000_0000_1000,
		PH_ID    = 11'b000_0001_0000,
		PH_LENHI = 11'b000_0010_0000,
		PH_LENLO = 11'b000_0100_0000,
		PH_CHAN  = 11'b000_1000_0000,
		PH_ADCHI = 11'b001_0000_0000,
		PH_ADCLO = 11'b010_0000_0000,
		PH_SKIP  = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [15:0] full_length_ab;
		logic [15:0] full_length_c;
		logic [4:0]  fees_per_event;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [3:0]        fee_id;
		logic [CHAN_W-1:0] channel;
		logic [15:0]       adc_value;
		logic [7:0]        trigger_tag;
		logic [3:0]        run_mode;
		err_t              error_code;
	} res_t;

endpackage

>>> design/ffd_core.sv
// ----------------------------------------------------------------------------
// ffd_core: frame parser state machine
// Consumes one stream byte per step, tracks the frame and event state and
// presents at most one result for that byte.
// ----------------------------------------------------------------------------
module ffd_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_in,
	input  logic          start_in,
	input  ffd_pkg::cfg_t cfg,
	output logic          res_valid,
	output ffd_pkg::res_t res
);
	import ffd_pkg::*;

	phase_t            phase_q, phase_d, ph;
	logic [4:0]        frame_q, frame_d, fc;
	logic [7:0]        trig_q, trig_d;
	logic [3:0]        mode_q, mode_d;
	logic [3:0]        fee_q, fee_d;
	logic [7:0]        len_hi_q, len_hi_d;
	logic [LEFT_W-1:0] left_q, left_d;
	logic              impl_q, impl_d;
	logic [CHAN_W-1:0] chan_q, chan_d;
	logic [7:0]        adc_hi_q, adc_hi_d;
	logic [2:0]        skip_q, skip_d;

	logic [15:0]       len;
	logic              len_impl;
	logic [15:0]       diff;
	logic [32:0]       prod;
	logic [LEFT_W-1:0] count;
	logic [5:0]        fc_next;

	assign len      = {len_hi_q, byte_in};
	assign len_impl = (len == cfg.full_length_ab) || (len == cfg.full_length_c);
	assign diff     = len - HDR_LEN;
	assign prod     = 33'(diff) * 33'(DIV3_MUL);
	assign fc_next  = {1'b0, fc} + 6'd1;

	always_comb begin
		if (len < HDR_LEN) begin
			count = '0;
		end else if (len_impl) begin
			count = diff[15:1];
		end else begin
			count = prod[DIV3_SHIFT+LEFT_W-1:DIV3_SHIFT];
		end
	end

	// a start flag restarts the event from any phase
	assign ph = start_in ? PH_SYNC1 : phase_q;
	assign fc = start_in ? 5'd0 : frame_q;

	always_comb begin
		phase_d  = ph;
		frame_d  = fc;
		trig_d   = trig_q;
		mode_d   = mode_q;
		fee_d    = fee_q;
		len_hi_d = len_hi_q;
		left_d   = left_q;
		impl_d   = impl_q;
		chan_d   = chan_q;
		adc_hi_d = adc_hi_q;
		skip_d   = skip_q;

		res_valid       = 1'b0;
		res.kind        = KIND_SAMPLE;
		res.fee_id      = '0;
		res.channel     = '0;
		res.adc_value   = '0;
		res.trigger_tag = trig_q;
		res.run_mode    = mode_q;
		res.error_code  = ERR_NONE;

		unique case (ph)
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
			PH_SYNC1: begin
				if (byte_in != SYNC_A) begin
					phase_d        = PH_IDLE;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_SYNC1;
				end else begin
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (byte_in != SYNC_B) begin
					phase_d        = PH_IDLE;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_SYNC2;
				end else begin
					phase_d = PH_TRIG;
				end
			end
			PH_TRIG: begin
				if (fc == 5'd0) begin
					trig_d  = byte_in;
					phase_d = PH_ID;
				end else if (byte_in != trig_q) begin
					phase_d        = PH_IDLE;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_TRIGGER;
				end else begin
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				if (fc != 5'd0 && byte_in[7:4] != mode_q) begin
					phase_d        = PH_IDLE;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_MODE;
				end else begin
					if (fc == 5'd0) begin
						mode_d = byte_in[7:4];
					end
					fee_d   = byte_in[3:0];
					phase_d = PH_LENHI;
				end
			end
			PH_LENHI: begin
				len_hi_d = byte_in;
				phase_d  = PH_LENLO;
			end
			PH_LENLO: begin
				impl_d = len_impl;
				left_d = count;
				chan_d = '0;
				if (count == '0) begin
					skip_d  = SKIP_BYTES;
					phase_d = PH_SKIP;
				end else begin
					phase_d = len_impl ? PH_ADCHI : PH_CHAN;
				end
			end
			PH_CHAN: begin
				chan_d  = {1'b0, byte_in};
				phase_d = PH_ADCHI;
			end
			PH_ADCHI: begin
				adc_hi_d = byte_in;
				phase_d  = PH_ADCLO;
			end
			PH_ADCLO: begin
				res_valid     = 1'b1;
				res.kind      = KIND_SAMPLE;
				res.fee_id    = fee_q;
				res.channel   = chan_q;
				res.adc_value = {adc_hi_q, byte_in};
				left_d        = left_q - 1'b1;
				if (impl_q) begin
					chan_d = chan_q + 1'b1;
				end
				if (left_d == '0) begin
					skip_d  = SKIP_BYTES;
					phase_d = PH_SKIP;
				end else begin
					phase_d = impl_q ? PH_ADCHI : PH_CHAN;
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 1'b1;
				if (skip_d == 3'd0) begin
					if (fc_next >= {1'b0, cfg.fees_per_event}) begin
						phase_d    = PH_IDLE;
						frame_d    = 5'd0;
						res_valid  = 1'b1;
						res.kind   = KIND_EVENT;
						res.fee_id = fee_q;
					end else begin
						frame_d = fc_next[4:0];
						phase_d = PH_SYNC1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			frame_q  <= '0;
			trig_q   <= '0;
			mode_q   <= '0;
			fee_q    <= '0;
			len_hi_q <= '0;
			left_q   <= '0;
			impl_q   <= 1'b0;
			chan_q   <= '0;
			adc_hi_q <= '0;
			skip_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			frame_q  <= frame_d;
			trig_q   <= trig_d;
			mode_q   <= mode_d;
			fee_q    <= fee_d;
			len_hi_q <= len_hi_d;
			left_q   <= left_d;
			impl_q   <= impl_d;
			chan_q   <= chan_d;
			adc_hi_q <= adc_hi_d;
			skip_q   <= skip_d;
		end
	end

endmodule

>>> design/fee_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// fee_frame_deframer_unit: front-end frame deframer
// Splits a raw byte stream of front-end frames into samples, event-done
// marks and framing errors.
// ----------------------------------------------------------------------------
// One raw byte is taken per clock cycle while the input is not stalled, with no
// gaps needed. An accepted byte sits in the input register until the output
// register can take a result; the parser state machine then updates once for it
// and writes any result to the output register. Input stall rises only while a
// result waits in the output register and a byte is already held in the input
// register.
// Configuration must be written through the plain write port only while no
// request is in flight; the block does not enforce this. Registers 0 and 1
// are the implicit-format frame lengths, register 2 the number of frames per event.
module fee_frame_deframer_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  ffd_pkg::cfg_index_t    cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             raw_byte,
	input  logic                   start_event,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ffd_pkg::kind_t         kind,
	output logic [3:0]             fee_id,
	output logic [ffd_pkg::CHAN_W-1:0] channel,
	output logic [15:0]            adc_value,
	output logic [7:0]             trigger_tag,
	output logic [3:0]             run_mode,
	output ffd_pkg::err_t          error_code
);
	import ffd_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       out_valid_q;
	res_t       out_q;
	logic       adv;
	logic       step;
	logic       res_valid;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_length_ab <= 16'd582;
			cfg_q.full_length_c  <= 16'd294;
			cfg_q.fees_per_event <= 5'd2;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FULL_AB: cfg_q.full_length_ab <= cfg_data;
				CFG_FULL_C:  cfg_q.full_length_c  <= cfg_data;
				CFG_FEES:    cfg_q.fees_per_event <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= raw_byte;
			start_s1 <= start_event;
		end
	end

	ffd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.start_in  (start_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign fee_id      = out_q.fee_id;
	assign channel     = out_q.channel;
	assign adc_value   = out_q.adc_value;
	assign trigger_tag = out_q.trigger_tag;
	assign run_mode    = out_q.run_mode;
	assign error_code  = out_q.error_code;

endmodule

>>> design/ffd_checker.sv
// ----------------------------------------------------------------------------
// ffd_checker: port-level checks of the frame deframer
// Watches the request channels and the result fields over time.
// ----------------------------------------------------------------------------
module ffd_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_stall,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  ffd_pkg::kind_t         kind,
	input  logic [3:0]             fee_id,
	input  logic [ffd_pkg::CHAN_W-1:0] channel,
	input  logic [15:0]            adc_value,
	input  ffd_pkg::err_t          error_code
);
	import ffd_pkg::*;

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(adc_value)
			&& $stable(channel) && $stable(error_code))
		else $error("result changed while stalled");

	// with the output register empty the input never stalls
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE && fee_id == 4'd0
			&& channel == '0 && adc_value == 16'd0)
		else $error("malformed error result");

	a_event_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EVENT |-> error_code == ERR_NONE && channel == '0
			&& adc_value == 16'd0)
		else $error("malformed event result");

	a_sample_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SAMPLE |-> error_code == ERR_NONE)
		else $error("sample carries an error code");

endmodule

bind fee_frame_deframer_unit ffd_checker u_ffd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kind       (kind),
	.fee_id     (fee_id),
	.channel    (channel),
	.adc_value  (adc_value),
	.error_code (error_code)
);

>>> sim/tb_fee_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// tb_fee_frame_deframer_unit: self-checking bench for the frame deframer
// Feeds raw front-end frame bytes through the valid/stall input, predicts
// every sample, event-done and error result with an in-bench parser, and
// compares the output stream field by field. Both sides idle at random and
// the receiver holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_fee_frame_deframer_unit;
	import ffd_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_AT       = 20;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic        is_cfg;
		cfg_index_t  idx;
		logic [15:0] data;
		logic [7:0]  raw;
		logic        start;
	} raw_req_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	cfg_index_t        cfg_index   = CFG_FULL_AB;
	logic [15:0]       cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [7:0]        raw_byte    = '0;
	logic              start_event = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	kind_t             kind;
	logic [3:0]        fee_id;
	logic [CHAN_W-1:0] channel;
	logic [15:0]       adc_value;
	logic [7:0]        trigger_tag;
	logic [3:0]        run_mode;
	err_t              error_code;

	fee_frame_deframer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.raw_byte    (raw_byte),
		.start_event (start_event),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.fee_id      (fee_id),
		.channel     (channel),
		.adc_value   (adc_value),
		.trigger_tag (trigger_tag),
		.run_mode    (run_mode),
		.error_code  (error_code)
	);

	raw_req_t raw_reqs[$];
	res_t     pending_results[$];

	// parser copy
	phase_t      ph;
	logic [4:0]  frame_no;
	logic [7:0]  ev_trig;
	logic [3:0]  ev_mode;
	logic [3:0]  cur_fee;
	logic [7:0]  len_hi;
	logic [15:0] chans_left;
	logic        implicit_fmt;
	logic [15:0] chan_idx;
	logic [7:0]  adc_hi;
	logic [2:0]  skip_cnt;
	logic [15:0] len_ab;
	logic [15:0] len_c;
	logic [4:0]  fees;

	// register values as seen while building stimulus
	logic [15:0] gen_ab   = 16'd582;
	logic [15:0] gen_c    = 16'd294;
	logic [4:0]  gen_fees = 5'd2;
	int          n_gen    = 0;

	int fails       = 0;
	int n_out       = 0;
	int in_gap      = 0;
	int out_wait    = 0;
	int hold_left   = 0;
	int settle_left = SETTLE_CYCLES;
	bit hold_done   = 1'b0;
	bit in_took     = 1'b0;
	bit out_took    = 1'b0;
	bit in_calm     = 1'b0;
	bit out_calm    = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want_v);
		if (got !== want_v)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want_v));
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic s);
		res_t        r;
		bit          hit;
		logic [15:0] len;
		int          cnt;
		hit = 1'b0;
		r = '0;
		if (s) begin
			frame_no = '0;
			ph = PH_SYNC1;
		end
		case (ph)
			PH_SYNC1: if (b != SYNC_A) r.error_code = ERR_SYNC1; else ph = PH_SYNC2;
			PH_SYNC2: if (b != SYNC_B) r.error_code = ERR_SYNC2; else ph = PH_TRIG;
			PH_TRIG: begin
				if (frame_no != 0 && b != ev_trig) r.error_code = ERR_TRIGGER;
				else begin
					if (frame_no == 0) ev_trig = b;
					ph = PH_ID;
				end
			end
			PH_ID: begin
				if (frame_no != 0 && b[7:4] != ev_mode) r.error_code = ERR_MODE;
				else begin
					if (frame_no == 0) ev_mode = b[7:4];
					cur_fee = b[3:0];
					ph = PH_LENHI;
				end
			end
			PH_LENHI: begin
				len_hi = b;
				ph = PH_LENLO;
			end
			PH_LENLO: begin
				len = {len_hi, b};
				implicit_fmt = (len == len_ab || len == len_c);
				if (len < HDR_LEN) cnt = 0;
				else cnt = implicit_fmt ? (len - 6) / 2 : (len - 6) / 3;
				chans_left = cnt;
				chan_idx = '0;
				if (chans_left == 0) begin
					skip_cnt = SKIP_BYTES;
					ph = PH_SKIP;
				end else begin
					ph = implicit_fmt ? PH_ADCHI : PH_CHAN;
				end
			end
			PH_CHAN: begin
				chan_idx = b;
				ph = PH_ADCHI;
			end
			PH_ADCHI: begin
				adc_hi = b;
				ph = PH_ADCLO;
			end
			PH_ADCLO: begin
				hit = 1'b1;
				r.kind = KIND_SAMPLE;
				r.fee_id = cur_fee;
				r.channel = chan_idx[CHAN_W-1:0];
				r.adc_value = {adc_hi, b};
				chans_left = chans_left - 1;
				if (implicit_fmt) chan_idx = chan_idx + 1;
				if (chans_left == 0) begin
					skip_cnt = SKIP_BYTES;
					ph = PH_SKIP;
				end else begin
					ph = implicit_fmt ? PH_ADCHI : PH_CHAN;
				end
			end
			PH_SKIP: begin
				skip_cnt = skip_cnt - 1;
				if (skip_cnt == 0) begin
					if ({1'b0, frame_no} + 6'd1 >= {1'b0, fees}) begin
						ph = PH_IDLE;
						frame_no = '0;
						hit = 1'b1;
						r.kind = KIND_EVENT;
						r.fee_id = cur_fee;
					end else begin
						frame_no = frame_no + 1;
						ph = PH_SYNC1;
					end
				end
			end
			default: ph = PH_IDLE;
		endcase
		if (r.error_code != ERR_NONE) begin
			r.kind = KIND_ERROR;
			ph = PH_IDLE;
			hit = 1'b1;
		end
		if (hit) begin
			r.trigger_tag = ev_trig;
			r.run_mode = ev_mode;
			pending_results.push_back(r);
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic s);
		raw_req_t r;
		r = '0;
		r.raw = b;
		r.start = s;
		raw_reqs.push_back(r);
		n_gen++;
	endtask

	task automatic push_cfg(input cfg_index_t idx, input logic [15:0] d);
		raw_req_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = d;
		raw_reqs.push_back(r);
		case (idx)
			CFG_FULL_AB: gen_ab = d;
			CFG_FULL_C:  gen_c = d;
			CFG_FEES:    gen_fees = d[4:0];
			default: ;
		endcase
	endtask

	task automatic add_noise();
		repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 255), 1'b0);
	endtask

	task automatic gen_event(input int nfr, input bit big);
		logic [7:0]  trig;
		logic [7:0]  b;
		logic [3:0]  mode;
		logic [15:0] len;
		int          cnt;
		int          sel;
		bit          impl;
		trig = $urandom_range(0, 255);
		mode = $urandom_range(0, 15);
		for (int f = 0; f < nfr; f++) begin
			if ($urandom_range(0, 39) == 0) begin
				b = $urandom_range(0, 255);
				if (b == SYNC_A) b = 8'h00;
				push_byte(b, f == 0);
				add_noise();
				return;
			end
			push_byte(SYNC_A, f == 0);
			if ($urandom_range(0, 39) == 0) begin
				b = $urandom_range(0, 255);
				if (b == SYNC_B) b = 8'h00;
				push_byte(b, 1'b0);
				add_noise();
				return;
			end
			push_byte(SYNC_B, 1'b0);
			if (f > 0 && $urandom_range(0, 24) == 0) begin
				push_byte(trig ^ $urandom_range(1, 255), 1'b0);
				add_noise();
				return;
			end
			push_byte(trig, 1'b0);
			b = $urandom_range(0, 15);
			b[7:4] = mode;
			if (f > 0 && $urandom_range(0, 24) == 0) begin
				b[7:4] = mode ^ $urandom_range(1, 15);
				push_byte(b, 1'b0);
				add_noise();
				return;
			end
			push_byte(b, 1'b0);
			sel = $urandom_range(0, 9);
			if (big || sel < 3) len = gen_ab;
			else if (sel < 5) len = gen_c;
			else if (sel < 8) len = $urandom_range(6, 21);
			else if (sel < 9) len = $urandom_range(0, 5);
			else len = $urandom_range(0, 65535);
			impl = (len == gen_ab || len == gen_c);
			if (len < HDR_LEN) cnt = 0;
			else cnt = impl ? (len - 6) / 2 : (len - 6) / 3;
			push_byte(len[15:8], 1'b0);
			push_byte(len[7:0], 1'b0);
			// oversized frames are cut short by the next start flag
			if (cnt > 40 && !big) begin
				repeat ($urandom_range(0, 12)) push_byte($urandom_range(0, 255), 1'b0);
				return;
			end
			for (int k = 0; k < cnt; k++) begin
				if (!impl) push_byte($urandom_range(0, 255), 1'b0);
				push_byte($urandom_range(0, 255), 1'b0);
				push_byte($urandom_range(0, 255), 1'b0);
			end
			if ($urandom_range(0, 29) == 0) return;
			repeat (4) push_byte($urandom_range(0, 255), 1'b0);
		end
		if ($urandom_range(0, 3) == 0) add_noise();
	endtask

	task automatic gen_phase(input int budget);
		int stop_at;
		stop_at = n_gen + budget;
		while (n_gen < stop_at) gen_event(gen_fees, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// input driver
	always @(negedge clk) begin : drive
		raw_req_t r;
		bit       wr;
		if (arst_n) begin
			wr = 1'b0;
			if (!in_valid || in_took) begin
				in_took = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (raw_reqs.size() == 0) begin
					in_valid <= 1'b0;
				end else if (raw_reqs[0].is_cfg) begin
					in_valid <= 1'b0;
					if (pending_results.size() == 0) begin
						if (settle_left > 0) begin
							settle_left--;
						end else begin
							r = raw_reqs.pop_front();
							wr = 1'b1;
							cfg_index <= r.idx;
							cfg_data <= r.data;
							case (r.idx)
								CFG_FULL_AB: len_ab = r.data;
								CFG_FULL_C:  len_c = r.data;
								CFG_FEES:    fees = r.data[4:0];
								default: ;
							endcase
							settle_left = SETTLE_CYCLES;
						end
					end
				end else begin
					r = raw_reqs.pop_front();
					raw_byte <= r.raw;
					start_event <= r.start;
					in_valid <= 1'b1;
					in_gap = in_calm ? 0 : $urandom_range(0, 15);
					if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
				end
			end
			cfg_wr_en <= wr;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (n_out >= HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (out_took) begin
				out_took = 1'b0;
				out_wait = out_calm ? 0 : $urandom_range(0, 15);
				if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
			end else if (out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (hold_left > 0) || (out_wait > 0);
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				deframe_byte(raw_byte, start_event);
				in_took = 1'b1;
			end
			if (out_valid && !out_stall) begin
				out_took = 1'b1;
				n_out++;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result kind %0d with none expected", kind));
				end else begin
					want = pending_results.pop_front();
					check_field("kind", kind, want.kind);
					check_field("fee_id", fee_id, want.fee_id);
					check_field("channel", channel, want.channel);
					check_field("adc_value", adc_value, want.adc_value);
					check_field("trigger_tag", trigger_tag, want.trigger_tag);
					check_field("run_mode", run_mode, want.run_mode);
					check_field("error_code", error_code, want.error_code);
				end
			end
		end
	end

	initial begin
		ph = PH_IDLE;
		frame_no = '0;
		ev_trig = '0;
		ev_mode = '0;
		cur_fee = '0;
		len_hi = '0;
		chans_left = '0;
		implicit_fmt = 1'b0;
		chan_idx = '0;
		adc_hi = '0;
		skip_cnt = '0;
		len_ab = 16'd582;
		len_c = 16'd294;
		fees = 5'd2;

		// ignored idle byte, bad first sync, bad second sync
		push_byte(SYNC_A, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(SYNC_A, 1'b1);
		push_byte(8'hFF, 1'b0);
		// start flag cutting into a header
		push_byte(SYNC_A, 1'b1);
		push_byte(SYNC_B, 1'b0);
		// two-frame event: explicit channel, then a short length
		push_byte(SYNC_A, 1'b1);
		push_byte(SYNC_B, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h09, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		repeat (4) push_byte(8'h00, 1'b0);
		push_byte(SYNC_A, 1'b0);
		push_byte(SYNC_B, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		repeat (4) push_byte(8'hFF, 1'b0);

		push_cfg(CFG_FULL_AB, 16'd14);
		push_cfg(CFG_FULL_C, 16'd11);
		push_cfg(CFG_FEES, 16'd3);
		gen_phase(100);

		push_cfg(CFG_FULL_AB, 16'd0);
		push_cfg(CFG_FULL_C, 16'hFFFF);
		push_cfg(CFG_FEES, 16'd16);
		gen_phase(110);

		push_cfg(CFG_FULL_AB, 16'd1040);
		push_cfg(CFG_FULL_C, 16'd0);
		push_cfg(CFG_FEES, 16'd1);
		gen_phase(80);

		push_cfg(CFG_FULL_AB, $urandom_range(6, 40));
		push_cfg(CFG_FULL_C, $urandom_range(6, 40));
		push_cfg(CFG_FEES, 16'd13);
		gen_phase(100);

		push_cfg(CFG_FULL_AB, 16'd14);
		push_cfg(CFG_FULL_C, 16'd11);
		push_cfg(CFG_FEES, $urandom_range(1, 16));
		gen_phase(90);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (raw_reqs.size() != 0 || in_valid) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
